### sv/msd_pkg.sv
// Shared types and constants for the swing/dynamics MIDI delay scheduler.
`timescale 1ns / 1ps
package msd_pkg;

    // Default slot count and note-key table size (channel x note)
    localparam int SLOT_COUNT_DEF = 16;
    localparam int KEY_W          = 11;
    localparam int NOTE_KEYS      = 2048;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // Command queue between front and back
    localparam int CMD_FIFO_DEPTH = 4;

    // Item kinds
    localparam logic OP_BLOCK = 1'b0;
    localparam logic OP_EVENT = 1'b1;

    // Upper status nibbles
    localparam logic [3:0] ST_NOTE_OFF = 4'h8;
    localparam logic [3:0] ST_NOTE_ON  = 4'h9;

    typedef enum logic [1:0] {
        CFG_GRID_STEPS = 2'd0,
        CFG_POCKET     = 2'd1,
        CFG_DYNAMICS   = 2'd2,
        CFG_LATENCY    = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        CMD_AGE   = 2'd0,
        CMD_EMIT  = 2'd1,
        CMD_SCHED = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        logic        op;
        logic [7:0]  msg_status;
        logic [6:0]  msg_data1;
        logic [6:0]  msg_data2;
        logic [12:0] sample_pos;
        logic [13:0] block_size;
        logic        host_playing;
        logic [39:0] ppq_start;
        logic [15:0] tempo_bpm;
        logic [18:0] sample_rate;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  out_status;
        logic [6:0]  out_data1;
        logic [6:0]  out_data2;
        logic [12:0] out_offset;
        logic        last;
    } out_item_t;

    // amount: block size for CMD_AGE, delay for CMD_SCHED
    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  status;
        logic [6:0]  data1;
        logic [6:0]  data2;
        logic [12:0] pos;
        logic [13:0] amount;
    } cmd_t;

    typedef struct packed {
        logic [7:0]  status;
        logic [6:0]  data1;
        logic [6:0]  data2;
        logic [13:0] remaining;
    } slot_t;

endpackage

### sv/midi_swing_delay_scheduler_unit.sv
// Top level of the swing/dynamics MIDI delay scheduler.
`timescale 1ns / 1ps
// Takes block-start and MIDI event beats one at a time and returns zero or more
// result beats per item, the final one flagged with last. After reset the unit
// zeroes every entry of its note delay table before item_ready rises;
// configuration writes are taken throughout. The front end hands a block start
// or pass-through message straight to the command queue, reads the stored delay
// for a note-off, and scales the velocity of a note-on; while the host plays at
// nonzero tempo and sample rate it also runs the 35-step bit-serial divider and
// the rounding checks of the offbeat test. A full command queue stalls the
// hand-over. The back end reads and checks each active slot and skips idle ones
// on a block start, limited by the registered read of the single slot RAM; a
// 4-deep command queue lets both ends run on their own.
module midi_swing_delay_scheduler_unit #(
    parameter int SLOT_COUNT = msd_pkg::SLOT_COUNT_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    output logic                           item_ready,
    input  msd_pkg::in_item_t              item,
    output logic                           result_valid,
    input  logic                           result_ready,
    output msd_pkg::out_item_t             result,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [msd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [msd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import msd_pkg::*;

    cmd_t push_cmd, pop_cmd;
    logic cmd_push, cmd_full, cmd_pop, cmd_empty;

    assign cfg_ready = 1'b1;

    msd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd_push   (cmd_push),
        .cmd        (push_cmd),
        .cmd_full   (cmd_full)
    );

    msd_cmd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (push_cmd),
        .full      (cmd_full),
        .pop       (cmd_pop),
        .pop_data  (pop_cmd),
        .empty     (cmd_empty)
    );

    msd_back #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (pop_cmd),
        .cmd_empty    (cmd_empty),
        .cmd_pop      (cmd_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );
endmodule

### sv/msd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module msd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end
endmodule

### sv/msd_front.sv
// Front end: config registers, item classification, velocity scaling, offbeat test, note delay table.
`timescale 1ns / 1ps
module msd_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  msd_pkg::in_item_t             item,
    input  logic                          cfg_valid,
    input  logic [msd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [msd_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                          cmd_push,
    output msd_pkg::cmd_t                 cmd,
    input  logic                          cmd_full
);
    import msd_pkg::*;

    localparam int DIV_STEPS = 35;
    localparam logic [17:0] HALF_STEP  = 18'h20000;
    localparam logic [18:0] THREE_HALF = 19'h60000;

    typedef enum logic [9:0] {
        F_CLEAR = 10'b0000000001,
        F_IDLE  = 10'b0000000010,
        F_MA    = 10'b0000000100,
        F_MB    = 10'b0000001000,
        F_DIV   = 10'b0000010000,
        F_C1    = 10'b0000100000,
        F_C2    = 10'b0001000000,
        F_C3    = 10'b0010000000,
        F_TRD   = 10'b0100000000,
        F_DONE  = 10'b1000000000
    } fstate_t;

    fstate_t           state_reg, state_next;
    logic [5:0]        grid_reg, grid_next;
    logic [8:0]        pocket_reg, pocket_next;
    logic [8:0]        dyn_reg, dyn_next;
    logic [12:0]       lat_reg, lat_next;
    logic [39:0]       ppq_reg, ppq_next;
    logic [15:0]       tempo_reg, tempo_next;
    logic [18:0]       rate_reg, rate_next;
    logic              play_reg, play_next;
    logic [KEY_W-1:0]  clr_reg, clr_next;
    in_item_t          item_reg, item_next;
    cmd_kind_t         kind_reg, kind_next;
    logic              tbl_wr_reg, tbl_wr_next;
    logic              note_on_reg, note_on_next;
    logic [12:0]       delay_reg, delay_next;
    logic [12:0]       dly_calc_reg, dly_calc_next;
    logic              ip0_reg, ip0_next;
    logic [17:0]       fa_reg, fa_next;
    logic [18:0]       gp_reg, gp_next;
    logic [32:0]       den_reg, den_next;
    logic [34:0]       num_reg, num_next;
    logic [32:0]       rem_reg, rem_next;
    logic              q0_reg, q0_next;
    logic [5:0]        cnt_reg, cnt_next;
    logic [51:0]       m_reg, m_next;
    logic              e1_reg, e1_next;

    // note delay table
    logic              tbl_we;
    logic [KEY_W-1:0]  tbl_waddr, tbl_raddr;
    logic [12:0]       tbl_wdata, tbl_rdata;

    msd_ram #(
        .WIDTH (13),
        .DEPTH (NOTE_KEYS)
    ) u_tbl (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    // arithmetic terms
    logic [15:0] vel_prod;
    logic [8:0]  vel_scaled;
    logic [6:0]  vel_clamped;
    logic [21:0] dly_prod;
    logic [14:0] dly_scaled;
    logic [45:0] ppq_prod;
    logic [33:0] rem_sh;
    logic [17:0] t1_mag;
    logic [18:0] t2_mag;
    logic [51:0] rem_q;
    logic        eligible;
    logic        is_on, is_off;
    logic [3:0]  hi_nib;
    logic [5:0]  grid_in;
    logic [8:0]  pocket_in, dyn_in;

    assign vel_prod   = 16'(item_reg.msg_data2) * 16'(dyn_reg);
    assign vel_scaled = 9'((17'(vel_prod) + 17'd128) >> 8);
    assign vel_clamped = (vel_scaled == 9'd0) ? 7'd1 :
                         (vel_scaled > 9'd127) ? 7'd127 : vel_scaled[6:0];
    assign dly_prod   = 22'(pocket_reg) * 22'(lat_reg);
    assign dly_scaled = 15'((23'(dly_prod) + 23'd128) >> 8);
    assign ppq_prod   = 46'(grid_reg) * 46'(ppq_reg);
    assign rem_sh     = {rem_reg, num_reg[34]};
    assign t1_mag     = HALF_STEP - fa_reg;
    assign t2_mag     = THREE_HALF - {1'b0, fa_reg};
    assign rem_q      = {1'b0, rem_reg, 18'd0};
    assign eligible   = play_reg && (tempo_reg != 16'd0) && (rate_reg != 19'd0);
    assign hi_nib     = item.msg_status[7:4];
    assign is_on      = (hi_nib == ST_NOTE_ON) && (item.msg_data2 != 7'd0);
    assign is_off     = (hi_nib == ST_NOTE_OFF) ||
                        ((hi_nib == ST_NOTE_ON) && (item.msg_data2 == 7'd0));
    assign grid_in    = cfg_data[5:0];
    assign pocket_in  = cfg_data[8:0];
    assign dyn_in     = cfg_data[8:0];

    assign item_ready = (state_reg == F_IDLE);

    // command toward the back end
    always_comb
    begin
        cmd.status = item_reg.msg_status;
        cmd.data1  = item_reg.msg_data1;
        cmd.data2  = item_reg.msg_data2;
        cmd.pos    = item_reg.sample_pos;
        if (tbl_wr_reg)
        begin
            cmd.kind = (delay_reg != 13'd0) ? CMD_SCHED : CMD_EMIT;
        end
        else
        begin
            cmd.kind = kind_reg;
        end
        cmd.amount = (kind_reg == CMD_AGE) ? item_reg.block_size : {1'b0, delay_reg};
    end

    // next-state logic
    always_comb
    begin
        state_next    = state_reg;
        grid_next     = grid_reg;
        pocket_next   = pocket_reg;
        dyn_next      = dyn_reg;
        lat_next      = lat_reg;
        ppq_next      = ppq_reg;
        tempo_next    = tempo_reg;
        rate_next     = rate_reg;
        play_next     = play_reg;
        clr_next      = clr_reg;
        item_next     = item_reg;
        kind_next     = kind_reg;
        tbl_wr_next   = tbl_wr_reg;
        note_on_next  = note_on_reg;
        delay_next    = delay_reg;
        dly_calc_next = dly_calc_reg;
        ip0_next      = ip0_reg;
        fa_next       = fa_reg;
        gp_next       = gp_reg;
        den_next      = den_reg;
        num_next      = num_reg;
        rem_next      = rem_reg;
        q0_next       = q0_reg;
        cnt_next      = cnt_reg;
        m_next        = m_reg;
        e1_next       = e1_reg;
        tbl_we        = 1'b0;
        tbl_waddr     = {item_reg.msg_status[3:0], item_reg.msg_data1};
        tbl_wdata     = note_on_reg ? delay_reg : 13'd0;
        tbl_raddr     = {item.msg_status[3:0], item.msg_data1};
        cmd_push      = 1'b0;

        // register writes, clamped to their legal range
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_GRID_STEPS: grid_next = (grid_in < 6'd4) ? 6'd4 :
                                            (grid_in > 6'd32) ? 6'd32 : grid_in;
                CFG_POCKET:     pocket_next = (pocket_in > 9'd256) ? 9'd256 : pocket_in;
                CFG_DYNAMICS:   dyn_next = (dyn_in > 9'd256) ? 9'd256 : dyn_in;
                CFG_LATENCY:    lat_next = cfg_data;
                default:        ;
            endcase
        end

        case (state_reg)
            // zero the delay table after reset
            F_CLEAR:
            begin
                tbl_we    = 1'b1;
                tbl_waddr = clr_reg;
                tbl_wdata = 13'd0;
                if (clr_reg == KEY_W'(NOTE_KEYS - 1))
                begin
                    state_next = F_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            // take a beat and sort it
            F_IDLE:
            begin
                if (item_valid)
                begin
                    item_next    = item;
                    kind_next    = CMD_EMIT;
                    tbl_wr_next  = 1'b0;
                    note_on_next = 1'b0;
                    if (item.op == OP_BLOCK)
                    begin
                        ppq_next   = item.ppq_start;
                        tempo_next = item.tempo_bpm;
                        rate_next  = item.sample_rate;
                        play_next  = item.host_playing;
                        kind_next  = CMD_AGE;
                        state_next = F_DONE;
                    end
                    else if (is_on)
                    begin
                        tbl_wr_next  = 1'b1;
                        note_on_next = 1'b1;
                        state_next   = F_MA;
                    end
                    else if (is_off)
                    begin
                        tbl_wr_next = 1'b1;
                        state_next  = F_TRD;
                    end
                    else
                    begin
                        state_next = F_DONE;
                    end
                end
            end
            // velocity scale and first products
            F_MA:
            begin
                item_next.msg_data2 = vel_clamped;
                ip0_next      = ppq_prod[18];
                fa_next       = ppq_prod[17:0];
                gp_next       = 19'(grid_reg) * 19'(item_reg.sample_pos);
                den_next      = (33'(rate_reg) << 14) - (33'(rate_reg) << 10);
                dly_calc_next = (dly_scaled > 15'd8191) ? 13'd8191 : dly_scaled[12:0];
                if (eligible)
                begin
                    state_next = F_MB;
                end
                else
                begin
                    delay_next = 13'd0;
                    state_next = F_DONE;
                end
            end
            F_MB:
            begin
                num_next   = 35'(gp_reg) * 35'(tempo_reg);
                rem_next   = 33'd0;
                cnt_next   = 6'd0;
                state_next = F_DIV;
            end
            // restoring divide, one quotient bit per cycle
            F_DIV:
            begin
                if (rem_sh >= {1'b0, den_reg})
                begin
                    rem_next = 33'(rem_sh - {1'b0, den_reg});
                    q0_next  = 1'b1;
                end
                else
                begin
                    rem_next = rem_sh[32:0];
                    q0_next  = 1'b0;
                end
                num_next = {num_reg[33:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 6'(DIV_STEPS - 1))
                begin
                    state_next = F_C1;
                end
            end
            // rounding carry: compare remainder against the two thresholds
            F_C1:
            begin
                m_next     = 52'(t1_mag) * 52'(den_reg);
                state_next = F_C2;
            end
            F_C2:
            begin
                e1_next    = fa_reg[17] || (rem_q >= m_reg);
                m_next     = 52'(t2_mag) * 52'(den_reg);
                state_next = F_C3;
            end
            F_C3:
            begin
                delay_next = (ip0_reg ^ q0_reg ^ e1_reg ^ (rem_q >= m_reg)) ?
                             dly_calc_reg : 13'd0;
                state_next = F_DONE;
            end
            // note-off: stored delay
            F_TRD:
            begin
                delay_next = tbl_rdata;
                state_next = F_DONE;
            end
            // hand the command over and update the table
            F_DONE:
            begin
                if (!cmd_full)
                begin
                    cmd_push   = 1'b1;
                    tbl_we     = tbl_wr_reg;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    // control and configuration state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= F_CLEAR;
            grid_reg    <= 6'd16;
            pocket_reg  <= 9'd0;
            dyn_reg     <= 9'd256;
            lat_reg     <= 13'd1764;
            ppq_reg     <= 40'd0;
            tempo_reg   <= 16'd0;
            rate_reg    <= 19'd48000;
            play_reg    <= 1'b0;
            clr_reg     <= '0;
            kind_reg    <= CMD_EMIT;
            tbl_wr_reg  <= 1'b0;
            note_on_reg <= 1'b0;
            cnt_reg     <= 6'd0;
        end
        else
        begin
            state_reg   <= state_next;
            grid_reg    <= grid_next;
            pocket_reg  <= pocket_next;
            dyn_reg     <= dyn_next;
            lat_reg     <= lat_next;
            ppq_reg     <= ppq_next;
            tempo_reg   <= tempo_next;
            rate_reg    <= rate_next;
            play_reg    <= play_next;
            clr_reg     <= clr_next;
            kind_reg    <= kind_next;
            tbl_wr_reg  <= tbl_wr_next;
            note_on_reg <= note_on_next;
            cnt_reg     <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        delay_reg    <= delay_next;
        dly_calc_reg <= dly_calc_next;
        ip0_reg      <= ip0_next;
        fa_reg       <= fa_next;
        gp_reg       <= gp_next;
        den_reg      <= den_next;
        num_reg      <= num_next;
        rem_reg      <= rem_next;
        q0_reg       <= q0_next;
        m_reg        <= m_next;
        e1_reg       <= e1_next;
    end
endmodule

### sv/msd_cmd_fifo.sv
// Short command queue between the front and back ends.
`timescale 1ns / 1ps
module msd_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  msd_pkg::cmd_t push_data,
    output logic          full,
    input  logic          pop,
    output msd_pkg::cmd_t pop_data,
    output logic          empty
);
    import msd_pkg::*;

    localparam int PTR_W = $clog2(CMD_FIFO_DEPTH);
    localparam int CNT_W = $clog2(CMD_FIFO_DEPTH + 1);

    cmd_t             mem_reg [CMD_FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CNT_W'(CMD_FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    // pointers and fill count
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end
endmodule

### sv/msd_back.sv
// Back end: delay slots, block aging scan, slot allocation and result output register.
`timescale 1ns / 1ps
module msd_back #(
    parameter int SLOT_COUNT = msd_pkg::SLOT_COUNT_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  msd_pkg::cmd_t      cmd,
    input  logic               cmd_empty,
    output logic               cmd_pop,
    output logic               result_valid,
    input  logic               result_ready,
    output msd_pkg::out_item_t result
);
    import msd_pkg::*;

    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    typedef enum logic [3:0] {
        B_IDLE  = 4'b0001,
        B_RD    = 4'b0010,
        B_CHK   = 4'b0100,
        B_FLUSH = 4'b1000
    } bstate_t;

    bstate_t               state_reg, state_next;
    logic [SLOT_COUNT-1:0] active_reg, active_next;
    logic [SLOT_W-1:0]     idx_reg, idx_next;
    logic [13:0]           bs_reg, bs_next;
    out_item_t             pend_reg, pend_next;
    logic                  pend_valid_reg, pend_valid_next;
    out_item_t             out_reg, out_next;
    logic                  out_valid_reg, out_valid_next;

    logic                  ram_we;
    logic [SLOT_W-1:0]     ram_waddr;
    slot_t                 ram_wdata, ram_rdata;
    logic                  free_found;
    logic [SLOT_W-1:0]     free_idx;
    logic                  can_load;
    logic                  sched_take;
    logic                  last_slot;

    msd_ram #(
        .WIDTH ($bits(slot_t)),
        .DEPTH (SLOT_COUNT)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    assign result       = out_reg;
    assign result_valid = out_valid_reg;
    assign can_load     = !out_valid_reg || result_ready;
    assign last_slot    = (idx_reg == SLOT_W'(SLOT_COUNT - 1));
    assign sched_take   = (cmd.kind == CMD_SCHED) && free_found;

    // lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (!active_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    // next-state logic
    always_comb
    begin
        state_next      = state_reg;
        active_next     = active_reg;
        idx_next        = idx_reg;
        bs_next         = bs_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !result_ready;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg;
        ram_wdata       = ram_rdata;
        cmd_pop         = 1'b0;

        case (state_reg)
            B_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop = 1'b1;
                    pend_next.out_status = cmd.status;
                    pend_next.out_data1  = cmd.data1;
                    pend_next.out_data2  = cmd.data2;
                    pend_next.out_offset = cmd.pos;
                    pend_next.last       = 1'b1;
                    if (cmd.kind == CMD_AGE)
                    begin
                        bs_next    = cmd.amount;
                        idx_next   = '0;
                        state_next = B_RD;
                    end
                    else if (sched_take)
                    begin
                        ram_we                = 1'b1;
                        ram_waddr             = free_idx;
                        ram_wdata.status      = cmd.status;
                        ram_wdata.data1       = cmd.data1;
                        ram_wdata.data2       = cmd.data2;
                        ram_wdata.remaining   = cmd.amount;
                        active_next[free_idx] = 1'b1;
                    end
                    else
                    begin
                        // pass-through, or no free slot
                        pend_valid_next = 1'b1;
                        state_next      = B_FLUSH;
                    end
                end
            end
            // skip inactive slots, else wait for the registered read data
            B_RD:
            begin
                if (active_reg[idx_reg])
                begin
                    state_next = B_CHK;
                end
                else if (last_slot)
                begin
                    state_next = B_FLUSH;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            // fire or age one slot
            B_CHK:
            begin
                if (ram_rdata.remaining < bs_reg)
                begin
                    if (!pend_valid_reg || can_load)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_next       = pend_reg;
                            out_next.last  = 1'b0;
                        end
                        pend_next.out_status = ram_rdata.status;
                        pend_next.out_data1  = ram_rdata.data1;
                        pend_next.out_data2  = ram_rdata.data2;
                        pend_next.out_offset = ram_rdata.remaining[12:0];
                        pend_next.last       = 1'b1;
                        pend_valid_next      = 1'b1;
                        active_next[idx_reg] = 1'b0;
                        state_next           = last_slot ? B_FLUSH : B_RD;
                        idx_next             = last_slot ? idx_reg : idx_reg + 1'b1;
                    end
                end
                else
                begin
                    ram_we              = 1'b1;
                    ram_wdata.remaining = ram_rdata.remaining - bs_reg;
                    state_next          = last_slot ? B_FLUSH : B_RD;
                    idx_next            = last_slot ? idx_reg : idx_reg + 1'b1;
                end
            end
            // final beat of the item carries last
            B_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = B_IDLE;
                end
                else if (can_load)
                begin
                    out_valid_next  = 1'b1;
                    out_next        = pend_reg;
                    out_next.last   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            active_reg     <= '0;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            active_reg     <= active_next;
            idx_reg        <= idx_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bs_reg   <= bs_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    // no held result survives the return to idle
    a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_IDLE) |-> !pend_valid_reg)
        else $error("pending result left over in idle");

    // a slot is only examined while it is in use
    a_chk_active: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_CHK) |-> active_reg[idx_reg])
        else $error("inactive slot examined");

    // scheduling takes exactly one free slot
    a_sched_one: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_IDLE && cmd_pop && sched_take) |=>
        ($countones(active_reg) == $past($countones(active_reg)) + 1))
        else $error("slot allocation did not take exactly one slot");

    // the flush beat is marked last
    a_flush_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_FLUSH && pend_valid_reg && can_load) |=>
        (result_valid && result.last))
        else $error("final beat of an item not marked last");
endmodule

### bench/midi_swing_delay_scheduler_unit_test.sv
// Self-checking testbench for the swing/dynamics MIDI delay scheduler.
`timescale 1ns / 1ps
module midi_swing_delay_scheduler_unit_test;
    import msd_pkg::*;

    localparam int SLOTS       = SLOT_COUNT_DEF;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_WAIT  = 200;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASES      = 6;
    localparam int PHASE_BEATS = 58;
    localparam int IN_W        = $bits(in_item_t);

    logic      clk;
    logic      rst_n;
    logic      item_valid;
    logic      item_ready;
    in_item_t  item;
    logic      result_valid;
    logic      result_ready;
    out_item_t result;
    logic      cfg_valid;
    logic      cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    midi_swing_delay_scheduler_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Scheduler shadow state
    logic [5:0]  grid_q;
    logic [8:0]  pocket_q;
    logic [8:0]  dyn_q;
    logic [12:0] latency_q;
    bit          slot_busy [SLOTS];
    logic [23:0] slot_msg  [SLOTS];
    logic [13:0] slot_left [SLOTS];
    logic [12:0] note_delay [NOTE_KEYS];
    logic [39:0] host_ppq;
    logic [15:0] host_tempo;
    logic [18:0] host_rate;
    bit          host_play;

    out_item_t pending_msgs[$];
    int        mismatches;
    int        beats_sent;
    int        msgs_seen;
    int        swung_notes;
    int        overflow_notes;
    int        cycles;
    bit        rx_quiet;
    bit        rx_hold_req;

    // Directed stimulus rows
    typedef struct {
        bit        is_cfg;
        cfg_reg_t  reg_sel;
        logic [12:0] reg_val;
        in_item_t  beat;
        bit        typed;
        out_item_t want;
    } step_row_t;

    step_row_t script[$];

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d messages outstanding",
                     cycles, pending_msgs.size());
            $display("** midi_swing_delay_scheduler_unit: FAILED **");
            $finish;
        end
    end

    function automatic in_item_t ev(logic [7:0] st, logic [6:0] d1, logic [6:0] d2,
                                    logic [12:0] pos);
        in_item_t b;
        b = '0;
        b.op = OP_EVENT;
        b.msg_status = st;
        b.msg_data1 = d1;
        b.msg_data2 = d2;
        b.sample_pos = pos;
        return b;
    endfunction

    function automatic in_item_t blk(logic [13:0] bs, bit play, logic [39:0] ppq,
                                     logic [15:0] tempo, logic [18:0] rate);
        in_item_t b;
        b = '0;
        b.op = OP_BLOCK;
        b.block_size = bs;
        b.host_playing = play;
        b.ppq_start = ppq;
        b.tempo_bpm = tempo;
        b.sample_rate = rate;
        return b;
    endfunction

    function automatic out_item_t msg(logic [7:0] st, logic [6:0] d1, logic [6:0] d2,
                                      logic [12:0] off);
        out_item_t m;
        m.out_status = st;
        m.out_data1 = d1;
        m.out_data2 = d2;
        m.out_offset = off;
        m.last = 1'b1;
        return m;
    endfunction

    // Offbeat test: step index floor(step position + 1/2) is odd
    function automatic bit on_offbeat(logic [12:0] pos);
        bit [63:0] a;
        bit [63:0] ip;
        bit [63:0] fa;
        bit [63:0] num;
        bit [63:0] den;
        bit [63:0] q;
        bit [63:0] r;
        bit [63:0] frac;
        a = 64'(grid_q) * 64'(host_ppq);
        ip = a >> 18;
        fa = a & 64'h3FFFF;
        num = 64'(grid_q) * 64'(pos) * 64'(host_tempo);
        den = 64'd15360 * 64'(host_rate);
        q = num / den;
        r = num % den;
        frac = fa * den + r * 64'd262144 + 64'd131072 * den;
        return ((ip + q + frac / (64'd262144 * den)) & 64'd1) != 0;
    endfunction

    function automatic void apply_reg(cfg_reg_t sel, logic [12:0] val);
        case (sel)
            CFG_GRID_STEPS: grid_q = (val[5:0] < 4) ? 6'd4 :
                                     (val[5:0] > 32 ? 6'd32 : val[5:0]);
            CFG_POCKET:     pocket_q = (val[8:0] > 256) ? 9'd256 : val[8:0];
            CFG_DYNAMICS:   dyn_q = (val[8:0] > 256) ? 9'd256 : val[8:0];
            CFG_LATENCY:    latency_q = val;
            default: ;
        endcase
    endfunction

    // Work out the messages one accepted beat produces
    function automatic void forecast(in_item_t b, ref out_item_t outs[$]);
        int unsigned delay;
        int unsigned vel;
        logic [10:0] key;
        logic [6:0]  d2;
        bit placed;
        outs.delete();
        if (b.op == OP_BLOCK)
        begin
            host_play = b.host_playing;
            host_ppq = b.ppq_start;
            host_tempo = b.tempo_bpm;
            host_rate = b.sample_rate;
            for (int i = 0; i < SLOTS; i++)
            begin
                if (!slot_busy[i])
                    continue;
                if (slot_left[i] < b.block_size)
                begin
                    outs = {outs, msg(slot_msg[i][23:16], slot_msg[i][14:8],
                                      slot_msg[i][6:0], slot_left[i][12:0])};
                    outs[outs.size()-1].last = 1'b0;
                    slot_busy[i] = 0;
                end
                else
                    slot_left[i] = slot_left[i] - b.block_size;
            end
        end
        else
        begin
            delay = 0;
            placed = 0;
            d2 = b.msg_data2;
            key = {b.msg_status[3:0], b.msg_data1};
            if (b.msg_status[7:4] == ST_NOTE_ON && d2 != 0)
            begin
                vel = (int'(d2) * int'(dyn_q) + 128) >> 8;
                d2 = (vel < 1) ? 7'd1 : (vel > 127 ? 7'd127 : 7'(vel));
                if (host_play && host_tempo != 0 && host_rate != 0
                    && on_offbeat(b.sample_pos))
                    delay = (int'(pocket_q) * int'(latency_q) + 128) >> 8;
                if (delay > 8191)
                    delay = 8191;
                note_delay[key] = 13'(delay);
            end
            else if (b.msg_status[7:4] == ST_NOTE_OFF || b.msg_status[7:4] == ST_NOTE_ON)
            begin
                delay = note_delay[key];
                note_delay[key] = '0;
            end
            if (delay > 0)
            begin
                for (int i = 0; i < SLOTS && !placed; i++)
                begin
                    if (!slot_busy[i])
                    begin
                        slot_busy[i] = 1;
                        slot_msg[i] = {b.msg_status, 1'b0, b.msg_data1, 1'b0, d2};
                        slot_left[i] = 14'(delay);
                        placed = 1;
                        swung_notes++;
                    end
                end
                if (!placed)
                    overflow_notes++;
            end
            if (!placed)
                outs = {outs, msg(b.msg_status, b.msg_data1, d2, b.sample_pos)};
        end
        if (outs.size() > 0)
            outs[outs.size()-1].last = 1'b1;
    endfunction

    // Result checker
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && result_valid && result_ready)
        begin
            msgs_seen <= msgs_seen + 1;
            if (pending_msgs.size() == 0)
            begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                    $display("unexpected result beat %h", result);
            end
            else
            begin
                want = pending_msgs.pop_front();
                if (result.out_status !== want.out_status
                    || result.out_data1 !== want.out_data1
                    || result.out_data2 !== want.out_data2
                    || result.out_offset !== want.out_offset || result.last !== want.last)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch: expected st=%h d1=%0d d2=%0d off=%0d last=%b",
                                 want.out_status, want.out_data1, want.out_data2,
                                 want.out_offset, want.last);
                        $display("          got      st=%h d1=%0d d2=%0d off=%0d last=%b",
                                 result.out_status, result.out_data1, result.out_data2,
                                 result.out_offset, result.last);
                    end
                end
            end
        end
    end

    // Result-side back pressure: random bursts, one long hold on request
    initial
    begin
        int n;
        result_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (rx_hold_req)
            begin
                rx_hold_req = 0;
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (rx_quiet || $urandom_range(0, 3) != 0)
            begin
                result_ready <= 1'b1;
                n = rx_quiet ? 1 : $urandom_range(1, 6);
                repeat (n) @(posedge clk);
            end
            else
            begin
                result_ready <= 1'b0;
                n = $urandom_range(1, 6);
                repeat (n) @(posedge clk);
            end
        end
    end

    task automatic wait_drained();
        while (pending_msgs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t sel, logic [12:0] val);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_reg(sel, val);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one beat; valid stays high until accepted
    task automatic send_beat(in_item_t b, bit typed, out_item_t want);
        out_item_t outs[$];
        item_valid <= 1'b1;
        item <= b;
        do
            @(posedge clk);
        while (!item_ready);
        forecast(b, outs);
        if (typed)
            pending_msgs = {pending_msgs, want};
        else
            foreach (outs[i])
                pending_msgs = {pending_msgs, outs[i]};
        beats_sent++;
    endtask

    // Random sender gap
    task automatic maybe_gap();
        if (!rx_quiet && $urandom_range(0, 3) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // Mostly playing-note traffic on a small key pool so note-offs find their delays
    function automatic in_item_t random_beat();
        in_item_t b;
        int pick;
        logic [3:0] chan;
        logic [6:0] note;
        b = IN_W'({$urandom, $urandom, $urandom, $urandom});
        pick = $urandom_range(0, 99);
        chan = ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'($urandom_range(0, 2));
        note = ($urandom_range(0, 7) == 0) ? 7'($urandom) : 7'($urandom_range(60, 65));
        if (pick < 25)
        begin
            b.op = OP_BLOCK;
            b.block_size = ($urandom_range(0, 19) == 0) ? 14'($urandom)
                                                         : 14'($urandom_range(1, 400));
            if ($urandom_range(0, 49) == 0)
                b.block_size = '0;
            b.host_playing = ($urandom_range(0, 9) != 0);
            b.ppq_start = {8'($urandom), $urandom};
            b.tempo_bpm = ($urandom_range(0, 19) == 0) ? 16'd0
                                                        : 16'($urandom_range(1, 65535));
            case ($urandom_range(0, 9))
                0: b.sample_rate = '0;
                1: b.sample_rate = 19'($urandom);
                2: b.sample_rate = 19'd44100;
                default: b.sample_rate = 19'($urandom_range(1, 384000));
            endcase
        end
        else
        begin
            b.op = OP_EVENT;
            b.msg_data1 = note;
            if (pick < 65)
            begin
                b.msg_status = {ST_NOTE_ON, chan};
                if (b.msg_data2 == 0)
                    b.msg_data2 = 7'd1;
            end
            else if (pick < 85)
            begin
                b.msg_status = {ST_NOTE_OFF, chan};
            end
            else if (pick < 90)
            begin
                b.msg_status = {ST_NOTE_ON, chan};
                b.msg_data2 = '0;
            end
            if (pick < 90 && $urandom_range(0, 3) != 0)
                b.sample_pos = 13'($urandom_range(0, 255));
        end
        return b;
    endfunction

    task automatic add_row(bit is_cfg, cfg_reg_t sel, logic [12:0] val, in_item_t b,
                           bit typed, out_item_t want);
        step_row_t r;
        r.is_cfg = is_cfg;
        r.reg_sel = sel;
        r.reg_val = val;
        r.beat = b;
        r.typed = typed;
        r.want = want;
        script = {script, r};
    endtask

    initial
    begin
        out_item_t none;
        in_item_t  b;
        none = '0;
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        mismatches = 0;
        beats_sent = 0;
        msgs_seen = 0;
        swung_notes = 0;
        overflow_notes = 0;
        cycles = 0;
        rx_quiet = 0;
        rx_hold_req = 0;
        grid_q = 6'd16;
        pocket_q = '0;
        dyn_q = 9'd256;
        latency_q = 13'd1764;
        foreach (slot_busy[i])
            slot_busy[i] = 0;
        foreach (note_delay[i])
            note_delay[i] = '0;
        host_ppq = '0;
        host_tempo = '0;
        host_rate = 19'd48000;
        host_play = 0;

        // Directed script: idle transport first, then swing at the extremes
        add_row(0, CFG_GRID_STEPS, 0, ev(8'h90, 60, 127, 0), 1, msg(8'h90, 60, 127, 0));
        add_row(0, CFG_GRID_STEPS, 0, ev(8'h91, 0, 1, 8191), 1, msg(8'h91, 0, 1, 8191));
        add_row(0, CFG_GRID_STEPS, 0, ev(8'h80, 60, 64, 5), 1, msg(8'h80, 60, 64, 5));
        add_row(0, CFG_GRID_STEPS, 0, ev(8'hF8, 127, 127, 100), 1,
                msg(8'hF8, 127, 127, 100));
        add_row(0, CFG_GRID_STEPS, 0, ev(8'h45, 3, 9, 7), 1, msg(8'h45, 3, 9, 7));
        add_row(0, CFG_GRID_STEPS, 0, ev(8'h9F, 127, 0, 1), 1, msg(8'h9F, 127, 0, 1));
        add_row(1, CFG_POCKET, 13'd256, none, 0, none);
        add_row(1, CFG_LATENCY, 13'd8191, none, 0, none);
        add_row(1, CFG_DYNAMICS, 13'd0, none, 0, none);
        add_row(0, CFG_GRID_STEPS, 0, blk(0, 1, 40'd16384, 16'd7680, 19'd48000), 0, none);
        add_row(0, CFG_GRID_STEPS, 0, ev(8'h92, 10, 127, 0), 0, none);
        add_row(0, CFG_GRID_STEPS, 0, ev(8'h82, 10, 50, 0), 0, none);
        add_row(0, CFG_GRID_STEPS, 0, blk(0, 1, 40'd16384, 16'd7680, 19'd48000), 0, none);
        add_row(0, CFG_GRID_STEPS, 0, blk(16383, 1, 40'd16384, 16'd7680, 19'd48000), 0, none);
        add_row(1, CFG_GRID_STEPS, 13'd0, none, 0, none);
        add_row(0, CFG_GRID_STEPS, 0, blk(100, 1, 40'd0, 16'd0, 19'd0), 0, none);
        add_row(0, CFG_GRID_STEPS, 0, ev(8'h93, 20, 100, 3), 0, none);
        add_row(1, CFG_GRID_STEPS, 13'd63, none, 0, none);
        add_row(1, CFG_DYNAMICS, 13'd256, none, 0, none);
        add_row(0, CFG_GRID_STEPS, 0, blk(1, 1, 40'hFF_FFFF_FFFF, 16'hFFFF, 19'd1), 0, none);
        add_row(0, CFG_GRID_STEPS, 0, ev(8'h9E, 127, 127, 8191), 0, none);
        add_row(0, CFG_GRID_STEPS, 0, ev(8'h8E, 127, 0, 0), 0, none);
        add_row(0, CFG_GRID_STEPS, 0, blk(8192, 0, 40'd0, 16'd0, 19'd384000), 0, none);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            if (script[i].is_cfg)
            begin
                item_valid <= 1'b0;
                write_reg(script[i].reg_sel, script[i].reg_val);
            end
            else
            begin
                maybe_gap();
                send_beat(script[i].beat, script[i].typed, script[i].want);
            end
        end
        item_valid <= 1'b0;

        // Random phases, each under its own register setting
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:
                begin
                    write_reg(CFG_GRID_STEPS, 13'd4);
                    write_reg(CFG_POCKET, 13'd256);
                    write_reg(CFG_DYNAMICS, 13'd256);
                    write_reg(CFG_LATENCY, 13'd8191);
                end
                1:
                begin
                    write_reg(CFG_GRID_STEPS, 13'd32);
                    write_reg(CFG_POCKET, 13'd128);
                    write_reg(CFG_DYNAMICS, 13'd0);
                    write_reg(CFG_LATENCY, 13'd0);
                end
                2:
                begin
                    write_reg(CFG_GRID_STEPS, 13'h1FFF);
                    write_reg(CFG_POCKET, 13'h1FFF);
                    write_reg(CFG_DYNAMICS, 13'h1FFF);
                    write_reg(CFG_LATENCY, 13'd1);
                end
                default:
                begin
                    write_reg(CFG_GRID_STEPS, 13'($urandom));
                    write_reg(CFG_POCKET, 13'($urandom_range(1, 300)));
                    write_reg(CFG_DYNAMICS, 13'($urandom));
                    write_reg(CFG_LATENCY, 13'($urandom_range(400, 8191)));
                end
            endcase
            if (p == 3)
                rx_hold_req = 1;
            if (p == PHASES - 1)
                rx_quiet = 1;
            for (int k = 0; k < PHASE_BEATS; k++)
            begin
                if (p == 4 && k == PHASE_BEATS / 2)
                begin
                    item_valid <= 1'b0;
                    do
                        @(posedge clk);
                    while (pending_msgs.size() != 0);
                end
                maybe_gap();
                b = random_beat();
                send_beat(b, 0, none);
            end
            item_valid <= 1'b0;
        end

        // Flush what is left in the slots, then drain
        write_reg(CFG_POCKET, 13'd0);
        send_beat(blk(14'h3FFF, 0, 40'd0, 16'd0, 19'd48000), 0, none);
        item_valid <= 1'b0;
        wait_drained();

        $display("%0d beats in, %0d results checked", beats_sent, msgs_seen);
        $display("%0d notes held in slots, %0d sent on at once with every slot busy",
                 swung_notes, overflow_notes);
        if (mismatches == 0 && pending_msgs.size() == 0)
            $display("** midi_swing_delay_scheduler_unit: PASSED **");
        else
        begin
            $display("%0d mismatches, %0d results never arrived", mismatches,
                     pending_msgs.size());
            $display("** midi_swing_delay_scheduler_unit: FAILED **");
        end
        $finish;
    end

endmodule
